### hw/rtl/qspd_pkg.sv
// Shared types, character codes and result kinds of the query-string percent decoder.
package qspd_pkg;

  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic [2:0] KIND_NAME   = 3'd0;
  localparam logic [2:0] KIND_VALUE  = 3'd1;
  localparam logic [2:0] KIND_COMMIT = 3'd2;
  localparam logic [2:0] KIND_DROP   = 3'd3;
  localparam logic [2:0] KIND_END    = 3'd4;

  localparam logic [1:0] ESC_IDLE = 2'd0;
  localparam logic [1:0] ESC_PCT  = 2'd1;
  localparam logic [1:0] ESC_HIGH = 2'd2;

  typedef enum logic [3:0] {
    PH_BEGIN = 4'b0001,
    PH_NAME  = 4'b0010,
    PH_VALUE = 4'b0100,
    PH_HALT  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] url_byte;
    logic       url_end;
  } url_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic       run_last;
  } res_t;

  // All results caused by one request, oldest in item[0].
  typedef struct packed {
    logic [1:0]     count;
    res_t [2:0]     item;
  } run_t;

  // Returns {invalid, digit}; invalid is set for anything but 0-9, a-f, A-F.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b1_0000;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r = {1'b0, c[3:0] + 4'd9};
    return r;
  endfunction

endpackage

### hw/rtl/qspd_parse.sv
// Parse state registers and the single-pass step logic for one URL character.
module qspd_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  qspd_pkg::url_t      url,
  output qspd_pkg::run_t      run
);

  qspd_pkg::phase_t phase, phase_next;
  logic [1:0] name_cnt, name_cnt_next, value_cnt, value_cnt_next;
  logic [3:0] name_hi, name_hi_next, value_hi, value_hi_next;

  logic       is_name, pending, pending_post, fail;
  logic [1:0] cnt_sel, cnt_new;
  logic [3:0] hi_sel, hi_new;
  logic [4:0] hx;
  logic [7:0] val;
  logic       act_valid, tail_valid;
  logic [2:0] act_kind, tail_kind;
  logic [7:0] act_data;
  logic [1:0] n;
  logic [7:0] b;

  always_comb begin
    b              = url.url_byte;
    phase_next     = phase;
    name_cnt_next  = name_cnt;
    name_hi_next   = name_hi;
    value_cnt_next = value_cnt;
    value_hi_next  = value_hi;
    is_name        = (phase == qspd_pkg::PH_NAME);
    cnt_sel        = is_name ? name_cnt : value_cnt;
    hi_sel         = is_name ? name_hi : value_hi;
    cnt_new        = cnt_sel;
    hi_new         = hi_sel;
    hx             = qspd_pkg::hex_val(b);
    val            = b;
    pending        = (name_cnt != qspd_pkg::ESC_IDLE) || (value_cnt != qspd_pkg::ESC_IDLE);
    fail           = 1'b0;
    act_valid      = 1'b0;
    act_kind       = qspd_pkg::KIND_DROP;
    act_data       = '0;

    if (phase != qspd_pkg::PH_HALT) begin
      if (b == qspd_pkg::CH_QUERY) begin
        phase_next = qspd_pkg::PH_NAME;
      end else if (b == qspd_pkg::CH_AMP || b == qspd_pkg::CH_SEMI) begin
        if (phase == qspd_pkg::PH_VALUE && !pending) begin
          act_valid      = 1'b1;
          act_kind       = qspd_pkg::KIND_COMMIT;
          phase_next     = qspd_pkg::PH_NAME;
          name_cnt_next  = qspd_pkg::ESC_IDLE;
          name_hi_next   = '0;
          value_cnt_next = qspd_pkg::ESC_IDLE;
          value_hi_next  = '0;
        end else begin
          fail = 1'b1;
        end
      end else if (b == qspd_pkg::CH_EQ) begin
        if (phase == qspd_pkg::PH_NAME) phase_next = qspd_pkg::PH_VALUE;
        else fail = 1'b1;
      end else if (phase == qspd_pkg::PH_NAME || phase == qspd_pkg::PH_VALUE) begin
        if (cnt_sel == qspd_pkg::ESC_IDLE) begin
          if (b == qspd_pkg::CH_PCT) begin
            cnt_new = qspd_pkg::ESC_PCT;
          end else begin
            val       = (b == qspd_pkg::CH_PLUS) ? qspd_pkg::CH_SPACE : b;
            act_valid = 1'b1;
          end
        end else if (hx[4]) begin
          fail = 1'b1;
        end else if (cnt_sel == qspd_pkg::ESC_PCT) begin
          hi_new  = hx[3:0];
          cnt_new = qspd_pkg::ESC_HIGH;
        end else begin
          val       = {hi_sel, hx[3:0]};
          cnt_new   = qspd_pkg::ESC_IDLE;
          hi_new    = '0;
          act_valid = 1'b1;
        end
        if (act_valid) begin
          act_kind = is_name ? qspd_pkg::KIND_NAME : qspd_pkg::KIND_VALUE;
          if (is_name && val >= qspd_pkg::CH_UP_A && val <= qspd_pkg::CH_UP_Z)
            act_data = val + qspd_pkg::CASE_OFS;
          else
            act_data = val;
        end
        if (is_name) begin
          name_cnt_next = cnt_new;
          name_hi_next  = hi_new;
        end else begin
          value_cnt_next = cnt_new;
          value_hi_next  = hi_new;
        end
      end
    end

    if (fail) begin
      act_valid      = 1'b1;
      act_kind       = qspd_pkg::KIND_DROP;
      act_data       = '0;
      phase_next     = qspd_pkg::PH_HALT;
      name_cnt_next  = qspd_pkg::ESC_IDLE;
      name_hi_next   = '0;
      value_cnt_next = qspd_pkg::ESC_IDLE;
      value_hi_next  = '0;
    end

    // The final character closes whatever parameter is still open.
    pending_post = (name_cnt_next != qspd_pkg::ESC_IDLE) ||
                   (value_cnt_next != qspd_pkg::ESC_IDLE);
    tail_valid   = 1'b0;
    tail_kind    = qspd_pkg::KIND_DROP;
    if (url.url_end) begin
      if (phase_next == qspd_pkg::PH_VALUE && !pending_post) begin
        tail_valid = 1'b1;
        tail_kind  = qspd_pkg::KIND_COMMIT;
      end else if (phase_next == qspd_pkg::PH_NAME || phase_next == qspd_pkg::PH_VALUE) begin
        tail_valid = 1'b1;
      end
      phase_next     = qspd_pkg::PH_BEGIN;
      name_cnt_next  = qspd_pkg::ESC_IDLE;
      name_hi_next   = '0;
      value_cnt_next = qspd_pkg::ESC_IDLE;
      value_hi_next  = '0;
    end

    run = '0;
    n   = 2'd0;
    if (act_valid) begin
      run.item[n].kind      = act_kind;
      run.item[n].data_byte = act_data;
      n = n + 2'd1;
    end
    if (tail_valid) begin
      run.item[n].kind = tail_kind;
      n = n + 2'd1;
    end
    if (url.url_end) begin
      run.item[n].kind = qspd_pkg::KIND_END;
      n = n + 2'd1;
    end
    if (n != 2'd0) run.item[n - 2'd1].run_last = 1'b1;
    run.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= qspd_pkg::PH_BEGIN;
      name_cnt  <= qspd_pkg::ESC_IDLE;
      name_hi   <= '0;
      value_cnt <= qspd_pkg::ESC_IDLE;
      value_hi  <= '0;
    end else if (advance) begin
      phase     <= phase_next;
      name_cnt  <= name_cnt_next;
      name_hi   <= name_hi_next;
      value_cnt <= value_cnt_next;
      value_hi  <= value_hi_next;
    end
  end

endmodule

### hw/rtl/qspd_resq.sv
// Three-entry result buffer for one request's results; drains one per cycle unless stalled.
module qspd_resq (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  qspd_pkg::run_t run,
  output logic           room,
  output logic           res_valid,
  input  logic           res_stall,
  output qspd_pkg::res_t res
);

  qspd_pkg::res_t [2:0] items;
  logic [1:0] cnt;
  logic [1:0] rd;
  logic       pop;

  assign res_valid = (cnt != 2'd0);
  assign pop       = res_valid && !res_stall;
  assign room      = (cnt == 2'd0) || (cnt == 2'd1 && pop);
  assign res       = items[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      rd  <= 2'd0;
    end else if (load) begin
      cnt <= run.count;
      rd  <= 2'd0;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
      rd  <= (cnt == 2'd1) ? 2'd0 : rd + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) items <= run.item;
  end

endmodule

### hw/rtl/query_string_percent_decoder.sv
// Top level of the query-string percent decoder: input register, parser and result buffer.
// One URL character is taken per request and each yields zero to three results (name or
// value byte, commit, drop, end marker), which leave one per cycle unless stalled;
// the last result of a request carries run_last. A character reaches the parser in the
// cycle after it is accepted, and its results are registered in the result buffer once
// that has room. With an output that never stalls the block takes one character per
// cycle while each yields at most one result; a character with more results holds back
// the next one until its last result is taken. The input register lets one more
// character in while results wait to be taken. No memories.
module query_string_percent_decoder (
  input  logic           clk,
  input  logic           rst,
  input  logic           url_valid,
  output logic           url_stall,
  input  qspd_pkg::url_t url,
  output logic           res_valid,
  input  logic           res_stall,
  output qspd_pkg::res_t res
);

  qspd_pkg::url_t held;
  logic           held_valid;
  logic           room;
  logic           load;
  logic           accept;
  qspd_pkg::run_t run;

  assign load      = held_valid && room;
  assign url_stall = held_valid && !room;
  assign accept    = url_valid && !url_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= accept || (held_valid && !load);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) held <= url;
  end

  qspd_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .advance (load),
    .url     (held),
    .run     (run)
  );

  qspd_resq u_resq (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .run       (run),
    .room      (room),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

### hw/rtl/qspd_checker.sv
// Port-level assertions for the query-string percent decoder and their bind.
module qspd_checker (
  input logic           clk,
  input logic           rst,
  input logic           url_valid,
  input logic           url_stall,
  input qspd_pkg::url_t url,
  input logic           res_valid,
  input logic           res_stall,
  input qspd_pkg::res_t res
);

  // Input backs up only while results are waiting.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    url_stall |-> res_valid)
    else $error("input stalled with no result pending");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result changed");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == qspd_pkg::KIND_END |-> res.run_last)
    else $error("end marker not last of its run");

  a_marker_data_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind != qspd_pkg::KIND_NAME && res.kind != qspd_pkg::KIND_VALUE
      |-> res.data_byte == 8'h00)
    else $error("marker result carries data");

  // A stalled request stays offered and unchanged until it is taken.
  a_request_holds: assert property (@(posedge clk) disable iff (rst)
    url_valid && url_stall |=> url_valid && $stable(url))
    else $error("stalled request changed");

endmodule

bind query_string_percent_decoder qspd_checker u_qspd_checker (
  .clk       (clk),
  .rst       (rst),
  .url_valid (url_valid),
  .url_stall (url_stall),
  .url       (url),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

### tb/query_string_percent_decoder_test.sv
// Self-checking testbench of the query-string percent decoder, with its own decoding predictor.
`timescale 1ns / 100ps

module query_string_percent_decoder_test;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic url_valid = 1'b0;
  logic url_stall;
  qspd_pkg::url_t url = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  qspd_pkg::res_t res;

  query_string_percent_decoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .url_valid (url_valid),
    .url_stall (url_stall),
    .url       (url),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always #1 clk = ~clk;

  // Predicted parser state.
  qspd_pkg::phase_t url_phase;
  logic [1:0] name_esc;
  logic [3:0] name_high;
  logic [1:0] value_esc;
  logic [3:0] value_high;

  qspd_pkg::res_t char_results[$];
  qspd_pkg::res_t results_due[$];
  qspd_pkg::res_t next_due;
  logic [7:0] url_text[$];

  int  error_count = 0;
  int  chars_sent = 0;
  int  hold_off_cycles = 0;
  int  hold_left;
  bit  sender_idles = 1'b0;
  bit  receiver_idles = 1'b0;

  task automatic report_error(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic void clear_escapes();
    name_esc   = qspd_pkg::ESC_IDLE;
    name_high  = '0;
    value_esc  = qspd_pkg::ESC_IDLE;
    value_high = '0;
  endfunction

  function automatic void reset_decoder_model();
    url_phase = qspd_pkg::PH_BEGIN;
    clear_escapes();
  endfunction

  function automatic void add_result(input logic [2:0] kind, input logic [7:0] data);
    qspd_pkg::res_t r;
    r.kind      = kind;
    r.data_byte = data;
    r.run_last  = 1'b0;
    char_results.push_back(r);
  endfunction

  function automatic void drop_and_halt();
    add_result(qspd_pkg::KIND_DROP, 8'h00);
    url_phase = qspd_pkg::PH_HALT;
    clear_escapes();
  endfunction

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
    if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
    return -1;
  endfunction

  // Percent-decodes one name or value character; each side has its own escape progress.
  function automatic void decode_field_char(input logic [7:0] b, input bit is_name);
    logic [1:0] cnt;
    logic [3:0] hi;
    logic [7:0] v;
    int         d;
    bit         emit_byte;
    bit         failed;
    cnt = is_name ? name_esc : value_esc;
    hi = is_name ? name_high : value_high;
    d = nibble_of(b);
    v = b;
    emit_byte = 1'b0;
    failed = 1'b0;
    if (cnt == qspd_pkg::ESC_IDLE) begin
      if (b == qspd_pkg::CH_PCT) cnt = qspd_pkg::ESC_PCT;
      else begin
        v = (b == qspd_pkg::CH_PLUS) ? qspd_pkg::CH_SPACE : b;
        emit_byte = 1'b1;
      end
    end else if (d < 0) begin
      failed = 1'b1;
    end else if (cnt == qspd_pkg::ESC_PCT) begin
      hi = d[3:0];
      cnt = qspd_pkg::ESC_HIGH;
    end else begin
      v = {hi, d[3:0]};
      cnt = qspd_pkg::ESC_IDLE;
      hi = '0;
      emit_byte = 1'b1;
    end
    if (failed) begin
      drop_and_halt();
    end else begin
      if (is_name) begin
        name_esc = cnt;
        name_high = hi;
      end else begin
        value_esc = cnt;
        value_high = hi;
      end
      if (emit_byte) begin
        if (is_name && v >= qspd_pkg::CH_UP_A && v <= qspd_pkg::CH_UP_Z)
          v = v + qspd_pkg::CASE_OFS;
        add_result(is_name ? qspd_pkg::KIND_NAME : qspd_pkg::KIND_VALUE, v);
      end
    end
  endfunction

  // Works out the results of one accepted request and queues them.
  function automatic void decode_url_char(input qspd_pkg::url_t u);
    logic [7:0]     b;
    logic           pending;
    qspd_pkg::res_t last_res;
    b = u.url_byte;
    char_results.delete();
    if (url_phase != qspd_pkg::PH_HALT) begin
      pending = name_esc != qspd_pkg::ESC_IDLE || value_esc != qspd_pkg::ESC_IDLE;
      if (b == qspd_pkg::CH_QUERY) begin
        url_phase = qspd_pkg::PH_NAME;
      end else if (b == qspd_pkg::CH_AMP || b == qspd_pkg::CH_SEMI) begin
        if (url_phase == qspd_pkg::PH_VALUE && !pending) begin
          add_result(qspd_pkg::KIND_COMMIT, 8'h00);
          url_phase = qspd_pkg::PH_NAME;
          clear_escapes();
        end else begin
          drop_and_halt();
        end
      end else if (b == qspd_pkg::CH_EQ) begin
        if (url_phase == qspd_pkg::PH_NAME) url_phase = qspd_pkg::PH_VALUE;
        else drop_and_halt();
      end else if (url_phase == qspd_pkg::PH_NAME) begin
        decode_field_char(b, 1'b1);
      end else if (url_phase == qspd_pkg::PH_VALUE) begin
        decode_field_char(b, 1'b0);
      end
    end
    if (u.url_end) begin
      pending = name_esc != qspd_pkg::ESC_IDLE || value_esc != qspd_pkg::ESC_IDLE;
      if (url_phase == qspd_pkg::PH_VALUE && !pending)
        add_result(qspd_pkg::KIND_COMMIT, 8'h00);
      else if (url_phase == qspd_pkg::PH_NAME || url_phase == qspd_pkg::PH_VALUE)
        add_result(qspd_pkg::KIND_DROP, 8'h00);
      add_result(qspd_pkg::KIND_END, 8'h00);
      reset_decoder_model();
    end
    if (char_results.size() > 0) begin
      last_res = char_results.pop_back();
      last_res.run_last = 1'b1;
      char_results.push_back(last_res);
    end
    foreach (char_results[i]) results_due.push_back(char_results[i]);
  endfunction

  // ---------------------------------------------------------------- result side

  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        hold_left = hold_off_cycles;
        hold_off_cycles = 0;
        res_stall <= 1'b1;
        while (hold_left > 0) begin
          @(posedge clk);
          hold_left--;
        end
        res_stall <= 1'b0;
      end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        res_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (results_due.size() == 0) begin
        report_error($sformatf("unexpected result kind %0d data %02h last %0b",
                               res.kind, res.data_byte, res.run_last));
      end else begin
        next_due = results_due.pop_front();
        if (res.kind !== next_due.kind)
          report_error($sformatf("kind %0d, expected %0d", res.kind, next_due.kind));
        if (res.data_byte !== next_due.data_byte)
          report_error($sformatf("data_byte %02h, expected %02h (kind %0d)",
                                 res.data_byte, next_due.data_byte, next_due.kind));
        if (res.run_last !== next_due.run_last)
          report_error($sformatf("run_last %0b, expected %0b (kind %0d)",
                                 res.run_last, next_due.run_last, next_due.kind));
      end
    end
  end

  // ---------------------------------------------------------------- request side

  task automatic send_char(input logic [7:0] b, input logic mark_end);
    qspd_pkg::url_t u;
    u.url_byte = b;
    u.url_end = mark_end;
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      url_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    url_valid <= 1'b1;
    url <= u;
    @(posedge clk);
    while (url_stall) @(posedge clk);
    decode_url_char(u);
    chars_sent++;
  endtask

  task automatic send_text(input string s, input bit mark_end);
    for (int i = 0; i < s.len(); i++) send_char(s[i], mark_end && i == s.len() - 1);
  endtask

  task automatic send_url_text();
    foreach (url_text[i]) send_char(url_text[i], i == url_text.size() - 1);
  endtask

  // ---------------------------------------------------------------- random URLs

  function automatic logic [7:0] plain_char();
    case ($urandom_range(0, 2))
      0: return 8'(8'h61 + $urandom_range(0, 25));
      1: return 8'(8'h41 + $urandom_range(0, 25));
      default: return 8'(8'h30 + $urandom_range(0, 9));
    endcase
  endfunction

  function automatic logic [7:0] hex_char(input int n);
    if (n < 10) return 8'(8'h30 + n);
    return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 10);
  endfunction

  function automatic logic [7:0] noise_char();
    if ($urandom_range(0, 1)) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0: return qspd_pkg::CH_QUERY;
      1: return qspd_pkg::CH_AMP;
      2: return qspd_pkg::CH_SEMI;
      3: return qspd_pkg::CH_EQ;
      4: return qspd_pkg::CH_PCT;
      default: return qspd_pkg::CH_PLUS;
    endcase
  endfunction

  function automatic void add_token();
    int r;
    r = $urandom_range(0, 11);
    if (r <= 4) begin
      url_text.push_back(plain_char());
    end else if (r == 5) begin
      url_text.push_back(qspd_pkg::CH_PLUS);
    end else if (r <= 9) begin
      url_text.push_back(qspd_pkg::CH_PCT);
      // Now and then the escape is split by a phase switch or carries a bad digit.
      if ($urandom_range(0, 9) == 0)
        url_text.push_back($urandom_range(0, 1) ? qspd_pkg::CH_QUERY : qspd_pkg::CH_EQ);
      url_text.push_back(hex_char($urandom_range(0, 15)));
      if ($urandom_range(0, 15) == 0) url_text.push_back(8'(8'h67 + $urandom_range(0, 19)));
      else url_text.push_back(hex_char($urandom_range(0, 15)));
    end else begin
      url_text.push_back(noise_char());
    end
  endfunction

  function automatic void build_random_url();
    int mode;
    int params;
    url_text.delete();
    mode = $urandom_range(0, 7);
    if (mode == 0) begin
      repeat ($urandom_range(1, 10)) url_text.push_back(noise_char());
      return;
    end
    repeat ($urandom_range(0, 2)) url_text.push_back(plain_char());
    url_text.push_back(qspd_pkg::CH_QUERY);
    params = $urandom_range(1, 3);
    for (int i = 0; i < params; i++) begin
      if (i > 0) url_text.push_back($urandom_range(0, 1) ? qspd_pkg::CH_AMP : qspd_pkg::CH_SEMI);
      repeat ($urandom_range(0, 3)) add_token();
      if (mode != 1 || $urandom_range(0, 1)) url_text.push_back(qspd_pkg::CH_EQ);
      repeat ($urandom_range(0, 3)) add_token();
    end
    if (mode == 2) url_text.push_back(qspd_pkg::CH_PCT);
    if (mode == 3) url_text.push_back($urandom_range(0, 1) ? qspd_pkg::CH_AMP : qspd_pkg::CH_SEMI);
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    // Escapes split by phase switches, case folding, raw extremes, a bad second digit, then URL ends.
    send_text("%+?Z%=%4?4A=1", 1'b0);
    send_char(8'hFF, 1'b0);
    send_text("+&", 1'b0);
    send_char(8'h00, 1'b0);
    send_text("=%3g;", 1'b0);
    send_text("=", 1'b1);
    send_text("&", 1'b1);
    send_text("=", 1'b1);
    send_text("?==q", 1'b1);
    send_text("?k=;", 1'b1);
    send_text("?%&x", 1'b1);
    send_text("?=%", 1'b1);
    send_text("?a=b", 1'b1);
  endtask

  // The result side holds off while requests keep coming, so the block backs up.
  task automatic test_receiver_hold();
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    hold_off_cycles = 120;
    send_text("?Alpha=Be%54a&Q+r=%7e%7E;x=9", 1'b1);
  endtask

  task automatic test_random_traffic(input int n_chars, input bit send_gaps,
                                     input bit recv_gaps);
    int start_count;
    start_count = chars_sent;
    sender_idles = send_gaps;
    receiver_idles = recv_gaps;
    while (chars_sent - start_count < n_chars) begin
      build_random_url();
      send_url_text();
    end
  endtask

  initial begin
    reset_decoder_model();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_receiver_hold();
    test_random_traffic(70, 1'b1, 1'b1);
    test_random_traffic(35, 1'b1, 1'b0);
    test_random_traffic(35, 1'b0, 1'b1);
    test_random_traffic(40, 1'b0, 1'b0);
    url_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### query_string_percent_decoder.f
hw/rtl/qspd_pkg.sv
hw/rtl/qspd_parse.sv
hw/rtl/qspd_resq.sv
hw/rtl/query_string_percent_decoder.sv
hw/rtl/qspd_checker.sv
tb/query_string_percent_decoder_test.sv
